/* rtl/wsd_pkg.sv */
// Shared types and constants of the websocket frame deframer.
package wsd_pkg;

  // Parse phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR1    = 5'b00001,
    PH_HDR2    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASKKEY = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Framing modes
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_WS  = 1'b1;

  // Register index, taken from paddr[2]
  localparam int  PADDR_W          = 3;
  localparam logic REG_FRAMING_MODE = 1'b0;

  // Frame header codes
  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [3:0] OPCODE_MASK  = 4'hf;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;

  // Header field byte counts
  localparam logic [3:0] EXT16_BYTES      = 4'd2;
  localparam logic [3:0] EXT64_BYTES      = 4'd8;
  localparam logic [3:0] XOR_KEY_BYTES    = 4'd4;
  localparam logic [3:0] LEN_PREFIX_BYTES = 4'd4;

endpackage

/* rtl/wsd_byte_if.sv */
// Valid/ready channel interfaces: received stream bytes and message output words.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       message_last;
  logic       message_empty;

  modport source (output valid, output payload_byte, output message_last,
                  output message_empty, input ready);
  modport sink   (input valid, input payload_byte, input message_last,
                  input message_empty, output ready);
endinterface

/* rtl/websocket_frame_deframer.sv */
// Websocket / raw length-prefix message deframer, one stream byte per word.
//
// Channels: rx carries received stream bytes (valid/ready), msg carries
// message words: payload_byte, message_last on the final byte, and
// message_empty for a zero-length message (one word with byte 0, last 1).
// The APB port holds framing_mode at address 0 (1 websocket, 0 raw 4-byte
// little-endian length prefix); writing it restarts parsing from a header.
// An accepted byte's word shows on msg in the next cycle. Throughput: one
// byte per cycle unless msg stalls; a parse step is one pass of logic from
// the accepted byte and parse state into the state and msg output register.
// Header, mask key and skipped-frame bytes give no word, bar the empty word
// of a zero-length message; only raw messages and websocket text frames
// (opcode 1) give words. Reset selects websocket mode, returns to the first
// header byte and empties the output register. When msg stalls, the output
// register holds its word and rx.ready drops only while that full register
// is not taken, so a byte is still accepted in the cycle that the word leaves.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  wsd_byte_if.sink           rx,
  wsd_msg_if.source          msg
);

  // Configuration and parse state
  logic        framing_mode;
  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [6:0]  len_code, len_code_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] xor_key, xor_key_next;
  logic [1:0]  mask_idx, mask_idx_next;

  // Output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_empty;

  // Step controls
  logic        accept;
  logic        cfg_write;
  logic        emit_all;
  logic        pay_step;
  logic        take_opcode;
  logic        after_len;
  logic        begin_pl;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_empty;
  logic [3:0]  cnt_inc;
  logic [3:0]  cnt_base;
  logic [63:0] rem_base;
  logic [3:0]  ext_need;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_FRAMING_MODE);
  assign rx.ready  = ~out_valid | msg.ready;
  assign accept    = rx.valid & rx.ready;
  assign emit_all  = (framing_mode == MODE_RAW);

  assign msg.valid         = out_valid;
  assign msg.payload_byte  = out_byte;
  assign msg.message_last  = out_last;
  assign msg.message_empty = out_empty;

  // Register read
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMING_MODE) begin
      prdata[0] = framing_mode;
    end
  end

  // Parse one byte
  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    masked_next    = masked;
    len_code_next  = len_code;
    hdr_count_next = hdr_count;
    remaining_next = remaining;
    xor_key_next   = xor_key;
    mask_idx_next  = mask_idx;
    pay_step       = 1'b0;
    take_opcode    = 1'b0;
    after_len      = 1'b0;
    begin_pl       = 1'b0;
    emit           = 1'b0;
    emit_byte      = '0;
    emit_last      = 1'b0;
    emit_empty     = 1'b0;
    cnt_inc        = hdr_count + 4'd1;
    cnt_base       = hdr_count;
    rem_base       = remaining;
    ext_need       = (len_code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;

    if (framing_mode == MODE_RAW) begin
      // Raw: payload bytes, or gather the little-endian length prefix
      if (phase == PH_PAYLOAD && remaining != '0) begin
        pay_step = 1'b1;
      end else begin
        cnt_base       = (phase != PH_HDR1) ? 4'd0 : hdr_count;
        rem_base       = (cnt_base == 4'd0) ? 64'd0 : remaining;
        phase_next     = PH_HDR1;
        remaining_next = rem_base |
                         (64'(rx.stream_byte) << {cnt_base[1:0], 3'b000});
        hdr_count_next = cnt_base + 4'd1;
        if (cnt_base + 4'd1 >= LEN_PREFIX_BYTES) begin
          masked_next = 1'b0;
          begin_pl    = 1'b1;
        end
      end
    end else begin
      // Websocket frame parse
      unique case (phase)
        PH_HDR2: begin
          masked_next    = rx.stream_byte[7];
          len_code_next  = rx.stream_byte[6:0];
          hdr_count_next = '0;
          if (rx.stream_byte[6:0] == LEN_CODE_16 ||
              rx.stream_byte[6:0] == LEN_CODE_64) begin
            remaining_next = '0;
            phase_next     = PH_EXTLEN;
          end else begin
            remaining_next = 64'(rx.stream_byte[6:0]);
            after_len      = 1'b1;
          end
        end
        PH_EXTLEN: begin
          remaining_next = {remaining[55:0], rx.stream_byte};
          hdr_count_next = cnt_inc;
          if (cnt_inc >= ext_need) begin
            after_len = 1'b1;
          end
        end
        PH_MASKKEY: begin
          xor_key_next   = {xor_key[23:0], rx.stream_byte};
          hdr_count_next = cnt_inc;
          if (cnt_inc >= XOR_KEY_BYTES) begin
            begin_pl = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (remaining != '0) begin
            pay_step = 1'b1;
          end else begin
            take_opcode = 1'b1;
          end
        end
        default: begin
          take_opcode = 1'b1;
        end
      endcase
    end

    // First header byte: latch opcode
    if (take_opcode) begin
      opcode_next = rx.stream_byte[3:0] & OPCODE_MASK;
      phase_next  = PH_HDR2;
    end

    // Payload byte: unmask, count down, mark the last
    if (pay_step) begin
      emit_byte      = masked ? (rx.stream_byte ^ xor_key[{~mask_idx, 3'b000} +: 8])
                              : rx.stream_byte;
      mask_idx_next  = mask_idx + 2'd1;
      remaining_next = remaining - 64'd1;
      emit_last      = (remaining == 64'd1);
      if (remaining == 64'd1) begin
        phase_next = PH_HDR1;
      end
      emit = emit_all | (opcode == OPCODE_TEXT);
    end

    // Length known: go to the mask key or the payload
    if (after_len) begin
      hdr_count_next = '0;
      if (masked_next) begin
        xor_key_next = '0;
        phase_next   = PH_MASKKEY;
      end else begin
        begin_pl = 1'b1;
      end
    end

    // Start the payload, or finish an empty message
    if (begin_pl) begin
      mask_idx_next  = '0;
      hdr_count_next = '0;
      if (remaining_next == '0) begin
        phase_next = PH_HDR1;
        emit       = emit_all | (opcode == OPCODE_TEXT);
        emit_byte  = '0;
        emit_last  = 1'b1;
        emit_empty = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode <= MODE_WS;
      phase        <= PH_HDR1;
      opcode       <= '0;
      masked       <= 1'b0;
      len_code     <= '0;
      hdr_count    <= '0;
      remaining    <= '0;
      xor_key      <= '0;
      mask_idx     <= '0;
    end else if (cfg_write) begin
      framing_mode <= pwdata[0];
      phase        <= PH_HDR1;
      opcode       <= '0;
      masked       <= 1'b0;
      len_code     <= '0;
      hdr_count    <= '0;
      remaining    <= '0;
      xor_key      <= '0;
      mask_idx     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      len_code     <= len_code_next;
      hdr_count    <= hdr_count_next;
      remaining    <= remaining_next;
      xor_key      <= xor_key_next;
      mask_idx     <= mask_idx_next;
    end
  end

  // Load the output word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit && !cfg_write) begin
      out_valid <= 1'b1;
    end else if (msg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit && !cfg_write) begin
      out_byte  <= emit_byte;
      out_last  <= emit_last;
      out_empty <= emit_empty;
    end
  end

endmodule

/* rtl/wsd_checker.sv */
// Port-level checks of the websocket frame deframer, bound to the top level.
module wsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic [7:0] msg_payload_byte,
  input logic       msg_message_last,
  input logic       msg_message_empty
);

  // Hold a stalled output word
  a_msg_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_ready |=> msg_valid && $stable(msg_payload_byte) &&
      $stable(msg_message_last) && $stable(msg_message_empty))
    else $error("stalled output word changed");

  // Empty message word is a last word with a zero byte
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_message_empty |-> msg_message_last && msg_payload_byte == 8'd0)
    else $error("empty message word malformed");

  // Accept input whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !msg_valid |-> rx_ready)
    else $error("input stalled with empty output register");

  // A new output word follows an accepted byte
  a_word_cause: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !$past(msg_valid) |-> $past(rx_valid && rx_ready))
    else $error("output word without accepted byte");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk               (clk),
  .rst               (rst),
  .rx_valid          (rx.valid),
  .rx_ready          (rx.ready),
  .msg_valid         (msg.valid),
  .msg_ready         (msg.ready),
  .msg_payload_byte  (msg.payload_byte),
  .msg_message_last  (msg.message_last),
  .msg_message_empty (msg.message_empty)
);
